FILE: rtl/core/pubs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pubs_pkg
// Shared constants and controller/datapath interface types of the periodic
// microframe bandwidth scheduler.
// ----------------------------------------------------------------------------
package pubs_pkg;

    localparam int FRAMES  = 32;
    localparam int UFRAMES = FRAMES * 8;
    localparam int ROW_W   = $clog2(FRAMES);
    localparam int UF_W    = $clog2(UFRAMES);

    localparam logic [7:0] LOAD_LIMIT_RST = 8'd187;
    localparam logic [9:0] NO_SCORE       = 10'd1023;

    localparam logic REQ_ADD    = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic clr_step;
        logic capture;
        logic scan_init;
        logic scan_step;
        logic place_init;
        logic place_step;
    } pubs_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic req_remove;
        logic scan_done;
        logic pipe_empty;
        logic fits;
        logic place_last;
    } pubs_stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/periodic_uframe_bandwidth_scheduler_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_uframe_bandwidth_scheduler_core
// Microframe load table with best-offset search for periodic endpoint adds
// and load release for removes.
// ----------------------------------------------------------------------------
// One request at a time: a request is taken when start is high and busy is
// low, and its single result appears on ok, chosen_offset and peak_load for
// exactly one cycle with done high; there is no backpressure on the result.
// After reset busy stays high while the load table is zeroed, one frame row
// per cycle. The table sits in eight byte lanes read once per cycle, so an
// add visits each period of every usable offset, steps past each unusable
// offset and drains the score pipeline; if the best peak fits load_limit it
// then rewrites each frame row touched by the placement. A remove rewrites
// each frame row touched. load_limit is written through cfg_we / cfg_wdata.
// ----------------------------------------------------------------------------
module periodic_uframe_bandwidth_scheduler_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic       req_type,
    input  wire logic [8:0] interval_uframes,
    input  wire logic [7:0] start_offset,
    input  wire logic [7:0] start_mask,
    input  wire logic [7:0] complete_mask,
    input  wire logic [7:0] start_time,
    input  wire logic [7:0] complete_time,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_wdata,
    output logic            done,
    output logic            ok,
    output logic [7:0]      chosen_offset,
    output logic [9:0]      peak_load
);

    pubs_pkg::pubs_cmd_t  cmd;
    pubs_pkg::pubs_stat_t stat;

    pubs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    pubs_dpath u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .req_type         (req_type),
        .interval_uframes (interval_uframes),
        .start_offset     (start_offset),
        .start_mask       (start_mask),
        .complete_mask    (complete_mask),
        .start_time       (start_time),
        .complete_time    (complete_time),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .ok               (ok),
        .chosen_offset    (chosen_offset),
        .peak_load        (peak_load)
    );

    // the result cycle always returns to idle
    a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("busy still high after result transfer");

    // scan never advances past the last candidate
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> !stat.scan_done)
        else $error("scan step issued after scan end");

    // placement starts only once every score is folded in
    a_place_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.place_init && !stat.req_remove) |-> stat.pipe_empty)
        else $error("placement started with scores in flight");

    // no usable offset can never report success
    a_no_offset_fails: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (peak_load == pubs_pkg::NO_SCORE)) |-> !ok)
        else $error("add reported success without a usable offset");

endmodule
`default_nettype wire

FILE: rtl/core/pubs_bank.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pubs_bank
// One byte lane of the load table: one row per frame, one write port and one
// registered read port.
// ----------------------------------------------------------------------------
module pubs_bank (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [pubs_pkg::ROW_W-1:0] waddr,
    input  wire logic [7:0]                 wdata,
    input  wire logic [pubs_pkg::ROW_W-1:0] raddr,
    output logic      [7:0]                 rdata
);

    logic [7:0] mem [pubs_pkg::FRAMES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/core/pubs_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pubs_dpath
// Request registers, load table banks, offset scan address generator, score
// pipeline with best-offset tracking, and the read-modify-write placement.
// ----------------------------------------------------------------------------
module pubs_dpath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire pubs_pkg::pubs_cmd_t  cmd,
    output pubs_pkg::pubs_stat_t      stat,
    input  wire logic                 req_type,
    input  wire logic [8:0]           interval_uframes,
    input  wire logic [7:0]           start_offset,
    input  wire logic [7:0]           start_mask,
    input  wire logic [7:0]           complete_mask,
    input  wire logic [7:0]           start_time,
    input  wire logic [7:0]           complete_time,
    input  wire logic                 cfg_we,
    input  wire logic [7:0]           cfg_wdata,
    output logic                      ok,
    output logic [7:0]                chosen_offset,
    output logic [9:0]                peak_load
);

    localparam int RW    = pubs_pkg::ROW_W;
    localparam int UW    = pubs_pkg::UF_W;
    localparam int PF_W  = RW + 2;
    localparam int SUM_W = ((UW > 9) ? UW : 9) + 1;

    function automatic logic [9:0] max10(input logic [9:0] a, input logic [9:0] b);
        max10 = (a > b) ? a : b;
    endfunction

    // request and configuration
    logic       req_type_reg;
    logic [8:0] interval_reg;
    logic [7:0] start_offset_reg;
    logic [7:0] smask_reg;
    logic [7:0] cmask_reg;
    logic [7:0] stime_reg;
    logic [7:0] ctime_reg;
    logic [7:0] load_limit_reg;

    // table clear
    logic [RW-1:0] clr_cnt_reg;

    // offset scan
    logic [8:0]    cand_reg;
    logic [UW-1:0] pos_reg;
    logic [8:0]    cand_limit;
    logic [8:0]    scan_stride;
    logic [8:0]    cand_inc;
    logic [SUM_W-1:0] pos_sum;
    logic          pos_last;
    logic [15:0]   cs_full;
    logic [15:0]   cc_full;
    logic          cand_ok;
    logic          scan_done;
    logic          issue;

    // score pipeline
    logic [7:0]    ssel0;
    logic [7:0]    csel0;
    logic          v1_reg;
    logic          last1_reg;
    logic [7:0]    off1_reg;
    logic [7:0]    ssel1_reg;
    logic [7:0]    csel1_reg;
    logic [9:0]    sum1 [8];
    logic          v2_reg;
    logic          last2_reg;
    logic [7:0]    off2_reg;
    logic [9:0]    sum2_reg [8];
    logic [9:0]    m4 [4];
    logic [9:0]    m2 [2];
    logic [9:0]    row_max;
    logic          v3_reg;
    logic          last3_reg;
    logic [7:0]    off3_reg;
    logic [9:0]    max3_reg;
    logic [9:0]    worst_now;
    logic          better;
    logic [9:0]    worst_reg;
    logic [9:0]    best_reg;
    logic [7:0]    chosen_reg;
    logic          found_reg;
    logic          fits;

    // placement
    logic [PF_W-1:0] prow_reg;
    logic [2:0]      psh_reg;
    logic [5:0]      frame_step;
    logic [PF_W-1:0] prow_sum;
    logic [7:0]      poff;
    logic [15:0]     psm_full;
    logic [15:0]     pcm_full;
    logic            pw_valid_reg;
    logic [RW-1:0]   pw_row_reg;

    // banks
    logic [7:0]    rd [8];
    logic [RW-1:0] srow [8];
    logic [RW-1:0] raddr [8];
    logic [7:0]    wdata [8];
    logic          bank_we;
    logic [RW-1:0] bank_waddr;

    assign cand_limit  = (interval_reg < 9'd256) ? interval_reg : 9'd256;
    assign scan_stride = (interval_reg > 9'd8) ? interval_reg : 9'd8;
    assign frame_step  = (interval_reg > 9'd8) ? interval_reg[8:3] : 6'd1;
    assign cand_inc    = cand_reg + 9'd1;
    assign pos_sum     = SUM_W'(pos_reg) + SUM_W'(scan_stride);
    assign pos_last    = (pos_sum >= SUM_W'(pubs_pkg::UFRAMES));

    // a candidate is usable when neither shifted mask leaves the frame
    assign cs_full   = {8'h00, smask_reg} << cand_reg[2:0];
    assign cc_full   = {8'h00, cmask_reg} << cand_reg[2:0];
    assign cand_ok   = (cs_full[15:8] == 8'h00) && (cc_full[15:8] == 8'h00)
                       && (32'(cand_reg) < 32'(pubs_pkg::UFRAMES));
    assign scan_done = (cand_reg >= cand_limit);
    assign issue     = cmd.scan_step && !scan_done && cand_ok;

    assign poff      = (req_type_reg == pubs_pkg::REQ_REMOVE) ? start_offset_reg : chosen_reg;
    assign psm_full  = {8'h00, smask_reg} << psh_reg;
    assign pcm_full  = {8'h00, cmask_reg} << psh_reg;
    assign prow_sum  = prow_reg + PF_W'(frame_step);

    assign bank_we    = cmd.clr_step | pw_valid_reg;
    assign bank_waddr = cmd.clr_step ? clr_cnt_reg : pw_row_reg;

    genvar b;
    for (b = 0; b < 8; b++)
    begin : g_lane
        localparam logic [2:0] BI = 3'(b);
        logic [2:0] j_b;
        logic [7:0] d_b;
        logic       use_b;

        // lane b holds microframe pos + j_b, which may sit in the next row
        assign j_b      = BI - pos_reg[2:0];
        assign srow[b]  = pos_reg[UW-1:3] + RW'(BI < pos_reg[2:0]);
        assign ssel0[b] = smask_reg[j_b];
        assign csel0[b] = cmask_reg[j_b];
        assign raddr[b] = cmd.place_step ? prow_reg[RW-1:0] : srow[b];

        assign use_b   = ssel1_reg[b] | csel1_reg[b];
        assign sum1[b] = use_b ? (10'(rd[b])
                                  + (ssel1_reg[b] ? 10'(stime_reg) : 10'd0)
                                  + (csel1_reg[b] ? 10'(ctime_reg) : 10'd0))
                               : 10'd0;

        assign d_b = (psm_full[b] ? stime_reg : 8'd0) + (pcm_full[b] ? ctime_reg : 8'd0);
        assign wdata[b] = cmd.clr_step ? 8'd0
                        : ((req_type_reg == pubs_pkg::REQ_REMOVE) ? (rd[b] - d_b)
                                                                  : (rd[b] + d_b));

        pubs_bank u_bank (
            .clk   (clk),
            .we    (bank_we),
            .waddr (bank_waddr),
            .wdata (wdata[b]),
            .raddr (raddr[b]),
            .rdata (rd[b])
        );
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            m4[k] = max10(sum2_reg[2 * k], sum2_reg[2 * k + 1]);
        end
        for (int k = 0; k < 2; k++)
        begin
            m2[k] = max10(m4[2 * k], m4[2 * k + 1]);
        end
        row_max = max10(m2[0], m2[1]);
    end

    assign worst_now = max10(worst_reg, max3_reg);
    assign better    = !found_reg || (worst_now <= best_reg);
    assign fits      = found_reg && (best_reg <= 10'(load_limit_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_limit_reg <= pubs_pkg::LOAD_LIMIT_RST;
            clr_cnt_reg    <= '0;
            cand_reg       <= '0;
            pos_reg        <= '0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            found_reg      <= 1'b0;
            pw_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                load_limit_reg <= cfg_wdata;
            end
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + RW'(1);
            end
            if (cmd.scan_init)
            begin
                cand_reg <= '0;
                pos_reg  <= '0;
            end
            else if (cmd.scan_step && !scan_done)
            begin
                if (!cand_ok || pos_last)
                begin
                    cand_reg <= cand_inc;
                    pos_reg  <= cand_inc[UW-1:0];
                end
                else
                begin
                    pos_reg <= pos_sum[UW-1:0];
                end
            end
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (cmd.scan_init)
            begin
                found_reg <= 1'b0;
            end
            else if (v3_reg && last3_reg)
            begin
                found_reg <= found_reg | better;
            end
            pw_valid_reg <= cmd.place_step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_type_reg     <= req_type;
            interval_reg     <= interval_uframes;
            start_offset_reg <= start_offset;
            smask_reg        <= start_mask;
            cmask_reg        <= complete_mask;
            stime_reg        <= start_time;
            ctime_reg        <= complete_time;
        end

        last1_reg <= pos_last;
        off1_reg  <= cand_reg[7:0];
        ssel1_reg <= ssel0;
        csel1_reg <= csel0;
        last2_reg <= last1_reg;
        off2_reg  <= off1_reg;
        for (int k = 0; k < 8; k++)
        begin
            sum2_reg[k] <= sum1[k];
        end
        last3_reg <= last2_reg;
        off3_reg  <= off2_reg;
        max3_reg  <= row_max;

        if (cmd.scan_init)
        begin
            best_reg   <= pubs_pkg::NO_SCORE;
            chosen_reg <= 8'd0;
            worst_reg  <= 10'd0;
        end
        else if (v3_reg)
        begin
            if (last3_reg)
            begin
                // ties go to the later offset
                if (better)
                begin
                    best_reg   <= worst_now;
                    chosen_reg <= off3_reg;
                end
                worst_reg <= 10'd0;
            end
            else
            begin
                worst_reg <= worst_now;
            end
        end

        if (cmd.place_init)
        begin
            prow_reg <= PF_W'(poff[7:3]);
            psh_reg  <= poff[2:0];
        end
        else if (cmd.place_step)
        begin
            prow_reg <= prow_sum;
        end
        pw_row_reg <= prow_reg[RW-1:0];
    end

    assign stat.clr_last   = (clr_cnt_reg == RW'(pubs_pkg::FRAMES - 1));
    assign stat.req_remove = (req_type_reg == pubs_pkg::REQ_REMOVE);
    assign stat.scan_done  = scan_done;
    assign stat.pipe_empty = !v1_reg && !v2_reg && !v3_reg;
    assign stat.fits       = fits;
    assign stat.place_last = (prow_sum >= PF_W'(pubs_pkg::FRAMES));

    assign ok            = (req_type_reg == pubs_pkg::REQ_REMOVE) | fits;
    assign chosen_offset = (req_type_reg == pubs_pkg::REQ_REMOVE) ? 8'd0 : chosen_reg;
    assign peak_load     = (req_type_reg == pubs_pkg::REQ_REMOVE) ? 10'd0 : best_reg;

endmodule
`default_nettype wire

FILE: rtl/core/pubs_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pubs_ctrl
// Sequencer: table clear after reset, request capture, offset scan, pipeline
// drain, placement and the result strobe.
// ----------------------------------------------------------------------------
module pubs_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire pubs_pkg::pubs_stat_t  stat,
    output pubs_pkg::pubs_cmd_t        cmd,
    output logic                       busy,
    output logic                       done
);

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_CLEAR    = 8'b0000_0010,
        ST_DISPATCH = 8'b0000_0100,
        ST_SCAN     = 8'b0000_1000,
        ST_DRAIN    = 8'b0001_0000,
        ST_PLACE    = 8'b0010_0000,
        ST_PWAIT    = 8'b0100_0000,
        ST_RESPOND  = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (stat.req_remove)
                begin
                    cmd.place_init = 1'b1;
                    state_next     = ST_PLACE;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_DRAIN:
            begin
                // best offset is final once the score pipeline is empty
                if (stat.pipe_empty)
                begin
                    if (stat.fits)
                    begin
                        cmd.place_init = 1'b1;
                        state_next     = ST_PLACE;
                    end
                    else
                    begin
                        state_next = ST_RESPOND;
                    end
                end
            end
            ST_PLACE:
            begin
                cmd.place_step = 1'b1;
                if (stat.place_last)
                begin
                    state_next = ST_PWAIT;
                end
            end
            ST_PWAIT:
            begin
                state_next = ST_RESPOND;
            end
            ST_RESPOND:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_RESPOND);

endmodule
`default_nettype wire
